FILE: src/kdpq_pkg.sv
`default_nettype none

package kdpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int HANDLE_BITS = 32;
  localparam int MAX_BITS    = 6;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Stream widths: data padded to whole bytes.
  localparam int IN_DATA_W   = ((HANDLE_BITS + 7) / 8) * 8;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = ((HANDLE_BITS + 2 * CNT_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = 2;

  localparam logic [MAX_BITS-1:0] MAX_RESET = MAX_BITS'(63);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

endpackage

`default_nettype wire

FILE: src/keyframe_drop_packet_queue.sv
// Keyframe-aware bounded packet queue over one 64-entry synchronous memory.
// An overflow walk drops one entry per step (one head read per drop) and,
// unless it drops a keyframe head alone, ends on a step that drops nothing.
// Throughput: one beat in flight; in_tready returns once the result is
// loaded into the output register. Reset (rst_n low, synchronous): queue
// empty, max_entries back to 63.
`default_nettype none

module keyframe_drop_packet_queue (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration: max_entries
  input  wire logic                             cfg_wen,
  input  wire logic [kdpq_pkg::MAX_BITS-1:0]    cfg_wdata,
  // input stream
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [kdpq_pkg::IN_DATA_W-1:0]   in_tdata,   // packet_handle
  input  wire logic [kdpq_pkg::IN_USER_W-1:0]   in_tuser,   // operation[1:0], is_keyframe
  // result stream
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [kdpq_pkg::OUT_DATA_W-1:0]  out_tdata,  // popped_handle, level,
                                                            // dropped_count, zero fill
  output      logic [kdpq_pkg::OUT_USER_W-1:0]  out_tuser   // pop_valid, popped_key
);

  import kdpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_WALK,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [ADDR_W-1:0]       head_r;
  logic [ADDR_W-1:0]       tail_r;
  logic [CNT_W-1:0]        count_r;
  logic [MAX_BITS-1:0]     max_r;
  logic [CNT_W-1:0]        dropped_r;
  logic                    pv_r;
  logic                    first_r;

  // Result register toward the output side.
  logic                    out_valid_r;
  logic [HANDLE_BITS-1:0]  out_handle_r;
  logic                    out_key_r;
  logic                    out_pv_r;
  logic [CNT_W-1:0]        out_level_r;
  logic [CNT_W-1:0]        out_dropped_r;

  // Entry store: handle in the upper bits, keyframe flag in bit 0.
  logic [HANDLE_BITS:0]    mem [QUEUE_DEPTH];
  logic [HANDLE_BITS:0]    rd_data_r;

  logic                    in_acc;
  op_t                     in_op;
  logic                    full;
  logic                    over;
  logic                    walk_drop;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser[1:0]);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign over      = (count_r > CNT_W'(max_r));
  // Drop the head unconditionally on the first step, then only non-keyframes;
  // a keyframe dropped on the first step ends the walk.
  assign walk_drop = (count_r != '0) && (first_r || !rd_data_r[0]);
  assign out_free  = !out_valid_r || out_tready;

  // Read the head on a pop, at the start of the overflow walk, and for the
  // entry behind each dropped head.
  assign rd_en   = (in_acc && (in_op == OP_POP)) ||
                   ((state_r == S_PUSH) && over) ||
                   ((state_r == S_WALK) && walk_drop);
  assign rd_addr = (state_r == S_WALK) ? ADDR_W'(head_r + 1'b1) : head_r;

  always_ff @(posedge clk) begin
    if (in_acc && (in_op == OP_PUSH)) begin
      mem[tail_r] <= {in_tdata[HANDLE_BITS-1:0], in_tuser[2]};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      max_r       <= MAX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        max_r <= cfg_wdata;
      end
      // Raise valid when a result is loaded, drop it once the beat is taken.
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_op)
              OP_PUSH: begin
                // Storage full: discard the head to make room.
                if (full) begin
                  head_r    <= head_r + 1'b1;
                  dropped_r <= CNT_W'(1);
                end else begin
                  count_r   <= count_r + 1'b1;
                  dropped_r <= '0;
                end
                tail_r  <= tail_r + 1'b1;
                pv_r    <= 1'b0;
                state_r <= S_PUSH;
              end
              OP_POP: begin
                pv_r <= (count_r != '0);
                if (count_r != '0) begin
                  head_r  <= head_r + 1'b1;
                  count_r <= count_r - 1'b1;
                end
                dropped_r <= '0;
                state_r   <= S_DONE;
              end
              OP_CLEAR: begin
                dropped_r <= count_r;
                count_r   <= '0;
                head_r    <= tail_r;
                pv_r      <= 1'b0;
                state_r   <= S_DONE;
              end
              OP_NOP: begin
                dropped_r <= '0;
                pv_r      <= 1'b0;
                state_r   <= S_DONE;
              end
            endcase
          end
        end
        S_PUSH: begin
          first_r <= 1'b1;
          state_r <= over ? S_WALK : S_DONE;
        end
        S_WALK: begin
          if (walk_drop) begin
            head_r    <= head_r + 1'b1;
            count_r   <= count_r - 1'b1;
            dropped_r <= dropped_r + 1'b1;
            first_r   <= 1'b0;
            // A keyframe head goes alone.
            if (rd_data_r[0]) begin
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free, then load the result.
          if (out_free) begin
            out_pv_r      <= pv_r;
            out_handle_r  <= pv_r ? rd_data_r[HANDLE_BITS:1] : '0;
            out_key_r     <= pv_r && rd_data_r[0];
            out_level_r   <= count_r;
            out_dropped_r <= dropped_r;
            state_r       <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_key_r, out_pv_r};

  always_comb begin
    out_tdata = '0;
    out_tdata[HANDLE_BITS-1:0]                       = out_handle_r;
    out_tdata[HANDLE_BITS+CNT_W-1:HANDLE_BITS]       = out_level_r;
    out_tdata[HANDLE_BITS+2*CNT_W-1:HANDLE_BITS+CNT_W] = out_dropped_r;
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import kdpq_pkg::*;

  // Run limits. A push can run an overflow walk that drops entries from the
  // head one by one before it ends, so settle for a full walk of the queue
  // before touching max_entries.
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 16;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_BEATS   = 100;

  // One expected result beat, fields as the block reports them.
  typedef struct packed {
    logic                   pop_valid;
    logic [HANDLE_BITS-1:0] handle;
    logic                   key;
    logic [CNT_W-1:0]       level;
    logic [CNT_W-1:0]       dropped;
  } queue_result_t;

  // Shadow copy of the packet queue: predicts each result from the accepted
  // beats and matches the result stream against it in order.
  class packet_queue_shadow;
    logic [HANDLE_BITS-1:0] slot_handle [QUEUE_DEPTH];
    logic                   slot_key    [QUEUE_DEPTH];
    int unsigned            rd_ptr;
    int unsigned            wr_ptr;
    int unsigned            held;
    int unsigned            keep_limit;
    int unsigned            err_count;
    queue_result_t          pending_results[$];

    function new();
      rd_ptr     = 0;
      wr_ptr     = 0;
      held       = 0;
      keep_limit = MAX_RESET;
      err_count  = 0;
    endfunction

    task report(string what, longint unsigned want, longint unsigned got);
      $display("testbench: mismatch on %s: expected %0h, got %0h at %0t",
               what, want, got, $realtime);
      err_count++;
    endtask

    function void retire_head();
      if (held == 0) return;
      rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
      held--;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void accept_beat(op_t op, logic [HANDLE_BITS-1:0] handle, logic key);
      queue_result_t r;
      int unsigned   lost;
      r    = '0;
      lost = 0;
      case (op)
        OP_PUSH: begin
          // storage full: evict the head before appending
          if (held >= QUEUE_DEPTH) begin
            retire_head();
            lost++;
          end
          slot_handle[wr_ptr] = handle;
          slot_key[wr_ptr]    = key;
          wr_ptr              = (wr_ptr + 1) % QUEUE_DEPTH;
          held++;
          // overflow: drop a keyframe head alone, else walk to the next keyframe
          if (held > keep_limit) begin
            if (slot_key[rd_ptr]) begin
              retire_head();
              lost++;
            end else begin
              while (held > 0 && !slot_key[rd_ptr]) begin
                retire_head();
                lost++;
              end
            end
          end
        end
        OP_POP: begin
          if (held > 0) begin
            r.pop_valid = 1'b1;
            r.handle    = slot_handle[rd_ptr];
            r.key       = slot_key[rd_ptr];
            retire_head();
          end
        end
        OP_CLEAR: begin
          lost   = held;
          held   = 0;
          rd_ptr = wr_ptr;
        end
        default: ;
      endcase
      r.level   = CNT_W'(held);
      r.dropped = CNT_W'(lost);
      pending_results.insert(pending_results.size(), r);
    endfunction

    task match_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        report("result beat with nothing pending", 0, data);
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (user[0] !== want.pop_valid)
        report("pop_valid", want.pop_valid, user[0]);
      if (data[HANDLE_BITS-1:0] !== want.handle)
        report("popped_handle", want.handle, data[HANDLE_BITS-1:0]);
      if (user[1] !== want.key)
        report("popped_key", want.key, user[1]);
      if (data[HANDLE_BITS +: CNT_W] !== want.level)
        report("level", want.level, data[HANDLE_BITS +: CNT_W]);
      if (data[HANDLE_BITS + CNT_W +: CNT_W] !== want.dropped)
        report("dropped_count", want.dropped, data[HANDLE_BITS + CNT_W +: CNT_W]);
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wen    = 1'b0;
  logic [MAX_BITS-1:0]   cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // packet_handle
  logic [IN_USER_W-1:0]  in_tuser   = '0;  // operation[1:0], is_keyframe
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // popped_handle, level, dropped_count, zero fill
  logic [OUT_USER_W-1:0] out_tuser;        // pop_valid, popped_key

  int unsigned send_idle_pct = 0;  // chance per cycle that the sender holds off
  int unsigned stall_pct     = 0;  // chance per cycle that the receiver stalls
  int unsigned cycle_count   = 0;

  packet_queue_shadow shadow = new();

  keyframe_drop_packet_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: check every accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      shadow.match_result(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one beat, hold it until accepted, then idle at random.
  task automatic send_beat(input op_t op, input logic [HANDLE_BITS-1:0] handle,
                           input logic key);
    in_tvalid <= 1'b1;
    in_tdata  <= handle;
    in_tuser  <= {key, op};
    do @(posedge clk); while (!in_tready);
    shadow.accept_beat(op, handle, key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every pending result is back and any walk is over.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write max_entries; only call right after settle.
  task automatic write_limit(input int unsigned limit);
    cfg_wen   <= 1'b1;
    cfg_wdata <= MAX_BITS'(limit);
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow.keep_limit = limit;
  endtask

  // Random operation mix: mostly pushes, some pops, a few clears and no-ops.
  function automatic op_t pick_op(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return OP_PUSH;
    if (roll < push_pct + 5) return OP_CLEAR;
    if (roll < push_pct + 9) return OP_NOP;
    return OP_POP;
  endfunction

  task automatic random_beats(input int unsigned count, input int unsigned push_pct,
                              input int unsigned key_pct);
    int unsigned i;
    for (i = 0; i < count; i++)
      send_beat(pick_op(push_pct), $urandom, ($urandom_range(99) < key_pct));
  endtask

  initial begin
    int unsigned phase;
    int unsigned push_pct;
    int unsigned key_pct;
    int unsigned limit;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, no-op and clear, then the field extremes.
    send_beat(OP_POP, '0, 1'b0);
    send_beat(OP_NOP, '1, 1'b1);
    send_beat(OP_CLEAR, '0, 1'b0);
    send_beat(OP_PUSH, '0, 1'b0);
    send_beat(OP_PUSH, '1, 1'b1);
    send_beat(OP_POP, $urandom, 1'b1);
    send_beat(OP_POP, '0, 1'b0);
    settle();

    // Small limit: walk to a keyframe, drop a keyframe head alone, walk to empty.
    write_limit(3);
    send_beat(OP_CLEAR, '0, 1'b0);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_PUSH, $urandom, 1'b1);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_CLEAR, '0, 1'b0);
    repeat (4) send_beat(OP_PUSH, $urandom, 1'b0);
    settle();

    // Limit of zero: every push overflows.
    write_limit(0);
    send_beat(OP_PUSH, $urandom, 1'b1);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_POP, '0, 1'b0);
    settle();

    // Lower the limit below the level: one policy run per push leaves it above.
    write_limit(63);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_PUSH, $urandom, 1'b1);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_PUSH, $urandom, 1'b0);
    settle();
    write_limit(2);
    send_beat(OP_PUSH, $urandom, 1'b0);
    send_beat(OP_CLEAR, '0, 1'b0);
    settle();

    // Random phases, one per idling pattern; change the limit halfway through.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  stall_pct = 0;  limit = 63;
          push_pct = 85; key_pct = 20;
        end
        1: begin
          send_idle_pct = 46; stall_pct = 0;  limit = $urandom_range(1, 6);
          push_pct = 55; key_pct = 25;
        end
        2: begin
          send_idle_pct = 0;  stall_pct = 46; limit = 1;
          push_pct = 60; key_pct = 50;
        end
        default: begin
          send_idle_pct = 31; stall_pct = 31; limit = $urandom_range(0, 63);
          push_pct = 70; key_pct = 15;
        end
      endcase
      write_limit(limit);
      random_beats(PHASE_BEATS / 2, push_pct, key_pct);
      settle();
      write_limit($urandom_range(0, 63));
      random_beats(PHASE_BEATS / 2, push_pct, key_pct);
      settle();
    end

    if (shadow.err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/kdpq_pkg.sv
src/keyframe_drop_packet_queue.sv
dv/testbench.sv
